// ===== sv/cbe_pkg.sv =====
`timescale 1ns / 1ps
package cbe_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int ITERATIONS_DEF = 16;

  // Unsigned values in [0, one]: t, 1 - t and their products.
  localparam int Q_W      = FRAC_BITS + 1;
  // Signed control y coefficients in [-one, 2*one].
  localparam int COEF_W   = FRAC_BITS + 3;
  // Signed partial products and polynomial sums.
  localparam int SUM_W    = FRAC_BITS + 5;
  localparam int PROD_W   = FRAC_BITS + SUM_W;
  localparam int PROG_W   = 18;
  localparam int EASED_W  = 19;
  localparam int CFG_X_W  = 17;
  localparam int CFG_Y_W  = 19;
  localparam int CFG_D_W  = 19;
  localparam int CFG_IDX_W = 2;

  localparam int ONE_INT = 1 << FRAC_BITS;

  typedef logic [Q_W-1:0]            q_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  localparam q_t    Q_ONE    = q_t'(ONE_INT);
  localparam q_t    Q_HALF   = q_t'(ONE_INT / 2);
  localparam coef_t COEF_MIN = coef_t'(-ONE_INT);
  localparam coef_t COEF_MAX = coef_t'(2 * ONE_INT);
  localparam sum_t  SUM_MIN  = sum_t'(-ONE_INT);
  localparam sum_t  SUM_MAX  = sum_t'(2 * ONE_INT);

  localparam logic [CFG_IDX_W-1:0] REG_CTRL_X1 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_Y1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_X2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_Y2 = 2'd3;

  localparam logic [CFG_X_W-1:0] RST_CTRL_X1 = 17'd20972;
  localparam logic [CFG_Y_W-1:0] RST_CTRL_Y1 = 19'd47186;
  localparam logic [CFG_X_W-1:0] RST_CTRL_X2 = 17'd0;
  localparam logic [CFG_Y_W-1:0] RST_CTRL_Y2 = 19'd65536;

  // Sideband of one bisection item.
  typedef struct packed {
    q_t lo;
    q_t hi;
    q_t t;
    q_t u;
    q_t x;
  } bis_t;

  // Terms of the polynomial: 3*pa + 3*pb + ttt.
  typedef struct packed {
    sum_t pa;
    sum_t pb;
    q_t   ttt;
  } poly_t;

  // Product of two values in [0, one], floored to Q.FRAC_BITS.
  function automatic q_t qmul_q(q_t a, q_t b);
    logic [2*Q_W-1:0] p;
    p = a * b;
    return p[FRAC_BITS +: Q_W];
  endfunction

  // Product of an unsigned value and a signed coefficient, floored.
  function automatic sum_t qmul_c(q_t a, coef_t c);
    logic signed [PROD_W-1:0] p;
    p = $signed({1'b0, a}) * c;
    return p[FRAC_BITS +: SUM_W];
  endfunction

  function automatic sum_t bez_sum(poly_t p);
    sum_t ttt_s;
    ttt_s = sum_t'(p.ttt);
    return (p.pa <<< 1) + p.pa + (p.pb <<< 1) + p.pb + ttt_s;
  endfunction

endpackage

// ===== sv/cubic_bezier_ease_bisect_unit.sv =====
`timescale 1ns / 1ps
// Cubic-bezier easing unit: for each progress value x in Q.16 (clamped to
// [0,1]) it finds the curve parameter t by ITERATIONS bisection halvings on
// the x polynomial and returns the y polynomial at the last midpoint, also
// Q.16, saturated to [-1,2]. The bisection is fully unrolled: an input
// register holds the first midpoint, every halving but the last is a
// four-stage slice (three multiplier ranks and a compare stage), and the
// final midpoint goes through one more three-stage multiplier slice for y and
// the output register. While the input is not stalled, one transaction can
// enter every cycle. A skid register at the output lets the pipeline keep
// moving while out_stall is high until a transaction reaches it; the input is
// stalled only while that skid register is full.
// The control points are to be written through the cfg port only while the
// unit is empty; the unit itself does not enforce this. All four cfg indexes
// select a register, and extra data bits are dropped.
module cubic_bezier_ease_bisect_unit #(
  parameter int ITERATIONS = cbe_pkg::ITERATIONS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [cbe_pkg::PROG_W-1:0]   in_progress,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cbe_pkg::EASED_W-1:0]  out_eased,
  input  logic                                cfg_we,
  input  logic [cbe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cbe_pkg::CFG_D_W-1:0]         cfg_data
);

  logic [cbe_pkg::CFG_X_W-1:0] ctrl_x1_r, ctrl_x2_r;
  logic [cbe_pkg::CFG_Y_W-1:0] ctrl_y1_r, ctrl_y2_r;
  cbe_pkg::coef_t              ax, bx, ay, by;
  logic                        en;

  logic                        chain_v   [ITERATIONS];
  cbe_pkg::bis_t               chain_bis [ITERATIONS];

  logic                        s0_valid_r;
  cbe_pkg::bis_t               s0_bis_r;
  cbe_pkg::q_t                 x_clamp;

  logic                        fin_valid;
  cbe_pkg::poly_t              fin_poly;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_x1_r <= cbe_pkg::RST_CTRL_X1;
      ctrl_y1_r <= cbe_pkg::RST_CTRL_Y1;
      ctrl_x2_r <= cbe_pkg::RST_CTRL_X2;
      ctrl_y2_r <= cbe_pkg::RST_CTRL_Y2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cbe_pkg::REG_CTRL_X1: ctrl_x1_r <= cfg_data[cbe_pkg::CFG_X_W-1:0];
        cbe_pkg::REG_CTRL_Y1: ctrl_y1_r <= cfg_data[cbe_pkg::CFG_Y_W-1:0];
        cbe_pkg::REG_CTRL_X2: ctrl_x2_r <= cfg_data[cbe_pkg::CFG_X_W-1:0];
        cbe_pkg::REG_CTRL_Y2: ctrl_y2_r <= cfg_data[cbe_pkg::CFG_Y_W-1:0];
        default: ;
      endcase
    end
  end

  // Control points are clamped on use; the registers keep what was written.
  always_comb begin
    ax = (ctrl_x1_r > cbe_pkg::Q_ONE) ? cbe_pkg::coef_t'(cbe_pkg::Q_ONE)
                                      : cbe_pkg::coef_t'(ctrl_x1_r);
    bx = (ctrl_x2_r > cbe_pkg::Q_ONE) ? cbe_pkg::coef_t'(cbe_pkg::Q_ONE)
                                      : cbe_pkg::coef_t'(ctrl_x2_r);
    priority if ($signed(ctrl_y1_r) < cbe_pkg::COEF_MIN) begin
      ay = cbe_pkg::COEF_MIN;
    end else if ($signed(ctrl_y1_r) > cbe_pkg::COEF_MAX) begin
      ay = cbe_pkg::COEF_MAX;
    end else begin
      ay = $signed(ctrl_y1_r);
    end
    priority if ($signed(ctrl_y2_r) < cbe_pkg::COEF_MIN) begin
      by = cbe_pkg::COEF_MIN;
    end else if ($signed(ctrl_y2_r) > cbe_pkg::COEF_MAX) begin
      by = cbe_pkg::COEF_MAX;
    end else begin
      by = $signed(ctrl_y2_r);
    end
  end

  always_comb begin
    priority if (in_progress[cbe_pkg::PROG_W-1]) begin
      x_clamp = '0;
    end else if (in_progress[cbe_pkg::Q_W-1:0] > cbe_pkg::Q_ONE) begin
      x_clamp = cbe_pkg::Q_ONE;
    end else begin
      x_clamp = in_progress[cbe_pkg::Q_W-1:0];
    end
  end

  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_bis_r.lo <= '0;
      s0_bis_r.hi <= cbe_pkg::Q_ONE;
      s0_bis_r.t  <= cbe_pkg::Q_HALF;
      s0_bis_r.u  <= cbe_pkg::Q_ONE - cbe_pkg::Q_HALF;
      s0_bis_r.x  <= x_clamp;
    end
  end

  assign chain_v[0]   = s0_valid_r;
  assign chain_bis[0] = s0_bis_r;

  // The last halving only moves lo or hi, which nothing reads afterwards, so
  // the y polynomial is evaluated directly at the midpoint that enters it.
  for (genvar i = 0; i < ITERATIONS - 1; i++) begin : g_iter
    cbe_iter u_iter (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (chain_v[i]),
      .in_bis   (chain_bis[i]),
      .coef_a   (ax),
      .coef_b   (bx),
      .out_valid(chain_v[i+1]),
      .out_bis  (chain_bis[i+1])
    );
  end

  cbe_poly u_ypoly (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (chain_v[ITERATIONS-1]),
    .in_bis   (chain_bis[ITERATIONS-1]),
    .coef_a   (ay),
    .coef_b   (by),
    .out_valid(fin_valid),
    .out_bis  (),
    .out_poly (fin_poly)
  );

  cbe_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .fin_valid(fin_valid),
    .fin_poly (fin_poly),
    .en       (en),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_eased(out_eased)
  );

endmodule

// ===== sv/cbe_poly.sv =====
`timescale 1ns / 1ps
module cbe_poly (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  cbe_pkg::bis_t  in_bis,
  input  cbe_pkg::coef_t coef_a,
  input  cbe_pkg::coef_t coef_b,
  output logic           out_valid,
  output cbe_pkg::bis_t  out_bis,
  output cbe_pkg::poly_t out_poly
);

  logic v1_r, v2_r, v3_r;
  cbe_pkg::bis_t  b1_r, b2_r, b3_r;
  cbe_pkg::q_t    uu1_r, ut1_r, tt1_r;
  cbe_pkg::q_t    uut2_r, utt2_r, ttt2_r;
  cbe_pkg::poly_t p3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Three multiplier ranks: squares, cubes, then the control coefficients.
  always_ff @(posedge clk) begin
    if (en) begin
      b1_r   <= in_bis;
      uu1_r  <= cbe_pkg::qmul_q(in_bis.u, in_bis.u);
      ut1_r  <= cbe_pkg::qmul_q(in_bis.u, in_bis.t);
      tt1_r  <= cbe_pkg::qmul_q(in_bis.t, in_bis.t);

      b2_r   <= b1_r;
      uut2_r <= cbe_pkg::qmul_q(uu1_r, b1_r.t);
      utt2_r <= cbe_pkg::qmul_q(ut1_r, b1_r.t);
      ttt2_r <= cbe_pkg::qmul_q(tt1_r, b1_r.t);

      b3_r     <= b2_r;
      p3_r.pa  <= cbe_pkg::qmul_c(uut2_r, coef_a);
      p3_r.pb  <= cbe_pkg::qmul_c(utt2_r, coef_b);
      p3_r.ttt <= ttt2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_bis   = b3_r;
  assign out_poly  = p3_r;

endmodule

// ===== sv/cbe_iter.sv =====
`timescale 1ns / 1ps
module cbe_iter (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  cbe_pkg::bis_t  in_bis,
  input  cbe_pkg::coef_t coef_a,
  input  cbe_pkg::coef_t coef_b,
  output logic           out_valid,
  output cbe_pkg::bis_t  out_bis
);

  logic                   pv;
  cbe_pkg::bis_t          pb;
  cbe_pkg::poly_t         pp;
  cbe_pkg::sum_t          xs;
  logic                   below;
  logic [cbe_pkg::Q_W:0]  up_sum, dn_sum;
  cbe_pkg::q_t            t_up, t_dn;
  cbe_pkg::bis_t          bis_nxt;
  logic                   valid_r;
  cbe_pkg::bis_t          bis_r;

  cbe_poly u_poly (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_bis   (in_bis),
    .coef_a   (coef_a),
    .coef_b   (coef_b),
    .out_valid(pv),
    .out_bis  (pb),
    .out_poly (pp)
  );

  // Both possible next midpoints are formed alongside the compare, so the
  // decision only selects between them.
  always_comb begin
    xs     = cbe_pkg::sum_t'(pb.x);
    below  = cbe_pkg::bez_sum(pp) < xs;
    up_sum = {1'b0, pb.t} + {1'b0, pb.hi};
    dn_sum = {1'b0, pb.lo} + {1'b0, pb.t};
    t_up   = up_sum[cbe_pkg::Q_W:1];
    t_dn   = dn_sum[cbe_pkg::Q_W:1];
    bis_nxt = pb;
    if (below) begin
      bis_nxt.lo = pb.t;
      bis_nxt.t  = t_up;
      bis_nxt.u  = cbe_pkg::Q_ONE - t_up;
    end else begin
      bis_nxt.hi = pb.t;
      bis_nxt.t  = t_dn;
      bis_nxt.u  = cbe_pkg::Q_ONE - t_dn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bis_r <= bis_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_bis   = bis_r;

endmodule

// ===== sv/cbe_outq.sv =====
`timescale 1ns / 1ps
module cbe_outq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              fin_valid,
  input  cbe_pkg::poly_t                    fin_poly,
  output logic                              en,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cbe_pkg::EASED_W-1:0] out_eased
);

  cbe_pkg::sum_t                       s;
  logic signed [cbe_pkg::EASED_W-1:0]  y;
  logic                                out_valid_r, skid_valid_r;
  logic signed [cbe_pkg::EASED_W-1:0]  out_eased_r, skid_eased_r;
  logic                                take;

  always_comb begin
    s = cbe_pkg::bez_sum(fin_poly);
    priority if (s < cbe_pkg::SUM_MIN) begin
      y = cbe_pkg::EASED_W'(cbe_pkg::SUM_MIN);
    end else if (s > cbe_pkg::SUM_MAX) begin
      y = cbe_pkg::EASED_W'(cbe_pkg::SUM_MAX);
    end else begin
      y = s[cbe_pkg::EASED_W-1:0];
    end
  end

  // The pipeline moves until the skid register holds a transaction.
  assign en   = !skid_valid_r;
  assign take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r  <= skid_valid_r || fin_valid;
      skid_valid_r <= 1'b0;
    end else if (en && fin_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_eased_r <= skid_valid_r ? skid_eased_r : y;
    end else if (en && fin_valid) begin
      skid_eased_r <= y;
    end
  end

  assign out_valid = out_valid_r;
  assign out_eased = out_eased_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a transaction while the output is empty");

  a_skid_fill_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid register filled while the output was free");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_stall |=> out_valid_r && !skid_valid_r)
    else $error("skid transaction not moved to the output");

  a_eased_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_eased_r >= cbe_pkg::EASED_W'(cbe_pkg::SUM_MIN)) &&
                    (out_eased_r <= cbe_pkg::EASED_W'(cbe_pkg::SUM_MAX)))
    else $error("eased value outside its saturation range");

endmodule
